// ===== src/otl_pkg.sv =====
// types and constants of the ordered timer list
// used by the channel interfaces, the core and the testbench
package otl_pkg;
    localparam int NOW_W = 48;
    localparam int DL_W  = 49;
    localparam int ID_W  = 32;
    localparam int TG_W  = 16;
    localparam int IV_W  = 32;

    localparam int MAX_RES = 16;
    localparam int RN_W    = 5;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] K_ADDED     = 3'd0;
    localparam logic [2:0] K_FULL      = 3'd1;
    localparam logic [2:0] K_REMOVED   = 3'd2;
    localparam logic [2:0] K_NOT_FOUND = 3'd3;
    localparam logic [2:0] K_FIRED     = 3'd4;
    localparam logic [2:0] K_NONE      = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [TG_W-1:0] target;
        logic [DL_W-1:0] deadline;
        logic [IV_W-1:0] interval;
        logic            once;
    } t_entry;
endpackage

// ===== src/otl_if.sv =====
// request and result channels of the ordered timer list
// depends on otl_pkg
interface otl_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [otl_pkg::NOW_W-1:0] now_ms;
    logic [31:0]               delay_ms;
    logic                      single_shot;
    logic [15:0]               target_handle;
    logic [31:0]               remove_id;
    modport source (output valid, op, now_ms, delay_ms, single_shot, target_handle,
                    remove_id, input ready);
    modport sink (input valid, op, now_ms, delay_ms, single_shot, target_handle,
                  remove_id, output ready);
endinterface

interface otl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] timer_id;
    logic [15:0] fired_target;
    logic        last;
    modport source (output valid, kind, timer_id, fired_target, last, input ready);
    modport sink (input valid, kind, timer_id, fired_target, last, output ready);
endinterface

// ===== src/otl_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module otl_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                          i_wdata,
    input  logic                                  i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                          o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule

// ===== src/ordered_timer_list_core.sv =====
// ordered timer list: an add gives its result from a registered output after acceptance;
// remove and tick scan the live entries through one ram read port and give their last
// result from the finishing state; a new request is taken only once the last result is pushed;
// fired results leave one per cycle, a stalled output holds the scan
// reset (synchronous, active low) empties the list and clears the id counter;
// the entry ram is not cleared, only the first live_count entries are read
module ordered_timer_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    otl_in_if.sink    i_req,
    otl_out_if.source o_res
);
    import otl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = $bits(t_entry);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_live, n_live;
    logic [ID_W-1:0]  r_next_id, n_next_id;
    logic [1:0]       r_op;
    logic [NOW_W-1:0] r_now;
    logic [IV_W-1:0]  r_delay;
    logic             r_once;
    logic [TG_W-1:0]  r_tgt;
    logic [ID_W-1:0]  r_rid;

    logic [CW-1:0]    r_ri, n_ri;
    logic [CW-1:0]    r_w, n_w;
    logic             r_pv, n_pv;
    logic             r_found, n_found;
    logic [RN_W-1:0]  r_n, n_n;
    logic             r_hv, n_hv;
    logic [ID_W-1:0]  r_hid, n_hid;
    logic [TG_W-1:0]  r_htg, n_htg;

    logic             r_ov;
    logic [2:0]       r_okind;
    logic [ID_W-1:0]  r_oid;
    logic [TG_W-1:0]  r_otg;
    logic             r_olast;

    logic             push;
    logic [2:0]       p_kind;
    logic [ID_W-1:0]  p_id;
    logic [TG_W-1:0]  p_tg;
    logic             p_last;
    logic             can_push;

    logic             we, re;
    logic [AW-1:0]    waddr;
    t_entry           wdata, q, upd;
    logic             due, keep, emit, stall;

    otl_ram #(.W(EW), .D(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_ri[AW-1:0]),
        .o_rdata (q)
    );

    assign can_push    = !r_ov || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_res.valid        = r_ov;
    assign o_res.kind         = r_okind;
    assign o_res.timer_id     = r_oid;
    assign o_res.fired_target = r_otg;
    assign o_res.last         = r_olast;

    always_comb begin
        n_state = r_state; n_live = r_live; n_next_id = r_next_id;
        n_ri = r_ri; n_w = r_w; n_pv = r_pv; n_found = r_found; n_n = r_n;
        n_hv = r_hv; n_hid = r_hid; n_htg = r_htg;
        push = 1'b0; p_kind = K_NONE; p_id = '0; p_tg = '0; p_last = 1'b1;
        we = 1'b0; re = 1'b0; waddr = r_live[AW-1:0];
        wdata.id = r_next_id; wdata.target = r_tgt;
        wdata.deadline = {1'b0, r_now} + {{(DL_W-IV_W){1'b0}}, r_delay};
        wdata.interval = r_delay; wdata.once = r_once;
        due = ({1'b0, r_now} >= q.deadline);
        upd = q;
        if (r_op == OP_REMOVE) begin
            keep = (q.id != r_rid);
            emit = 1'b0;
        end else begin
            keep = !(due && q.once);
            emit = due && (r_n < RN_W'(MAX_RES));
            if (due) begin
                upd.deadline = {1'b0, r_now} + {{(DL_W-IV_W){1'b0}}, q.interval};
            end
        end
        stall = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_ri = '0; n_w = '0; n_pv = 1'b0; n_found = 1'b0;
                    n_n = '0; n_hv = 1'b0;
                    if (i_req.op == OP_ADD) begin
                        n_state = S_ADD;
                    end else if (i_req.op == OP_REMOVE || i_req.op == OP_TICK) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_ADD: begin
                if (can_push) begin
                    push = 1'b1;
                    n_state = S_IDLE;
                    if (r_live == CW'(CAPACITY)) begin
                        p_kind = K_FULL;
                    end else begin
                        we = 1'b1;
                        p_kind = K_ADDED; p_id = r_next_id;
                        n_live = r_live + 1'b1;
                        n_next_id = r_next_id + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (r_pv) begin
                    // a new fire displaces the held one into the output
                    stall = emit && r_hv && !can_push;
                    if (!stall) begin
                        if (keep) begin
                            we = 1'b1; waddr = r_w[AW-1:0]; wdata = upd;
                            n_w = r_w + 1'b1;
                        end else if (r_op == OP_REMOVE) begin
                            n_found = 1'b1;
                        end
                        if (emit) begin
                            if (r_hv) begin
                                push = 1'b1; p_kind = K_FIRED; p_id = r_hid;
                                p_tg = r_htg; p_last = 1'b0;
                            end
                            n_hv = 1'b1; n_hid = q.id; n_htg = q.target;
                            n_n = r_n + 1'b1;
                        end
                    end
                end
                if (!stall) begin
                    re = (r_ri < r_live);
                    n_pv = re;
                    if (re) begin
                        n_ri = r_ri + 1'b1;
                    end else if (!r_pv) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (can_push) begin
                    push = 1'b1; n_state = S_IDLE; n_live = r_w;
                    if (r_op == OP_REMOVE) begin
                        p_kind = r_found ? K_REMOVED : K_NOT_FOUND; p_id = r_rid;
                    end else if (r_hv) begin
                        p_kind = K_FIRED; p_id = r_hid; p_tg = r_htg;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_live <= '0; r_next_id <= '0;
            r_pv <= 1'b0; r_hv <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_live <= n_live; r_next_id <= n_next_id;
            r_pv <= n_pv; r_hv <= n_hv;
            r_ov <= push || (r_ov && !o_res.ready);
        end
        r_ri <= n_ri; r_w <= n_w; r_found <= n_found; r_n <= n_n;
        r_hid <= n_hid; r_htg <= n_htg;
        if (i_req.valid && i_req.ready) begin
            r_op <= i_req.op; r_now <= i_req.now_ms; r_delay <= i_req.delay_ms;
            r_once <= i_req.single_shot; r_tgt <= i_req.target_handle;
            r_rid <= i_req.remove_id;
        end
        if (push) begin
            r_okind <= p_kind; r_oid <= p_id; r_otg <= p_tg; r_olast <= p_last;
        end
    end
endmodule

// ===== dv/tb_ordered_timer_list_core.sv =====
// testbench of the ordered timer list core: directed table, then random requests,
// every result checked against a behavioral list model or a typed row's result; depends on otl_pkg, otl_if
module tb_ordered_timer_list_core;
    import otl_pkg::*;

    localparam int CAP = 16;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [15:0] tgt;
        logic        last;
    } t_result;

    typedef struct {
        logic [1:0]  op;
        logic [47:0] now;
        logic [31:0] delay;
        logic        once;
        logic [15:0] tgt;
        logic [31:0] rid;
        bit          typed;
        t_result     res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    otl_in_if  req_if();
    otl_out_if res_if();

    ordered_timer_list_core #(.CAPACITY(CAP)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_res(res_if.source)
    );

    // list model
    t_entry  list_q[$];
    logic [31:0] id_ctr;
    t_result pending_q[$];
    int errors;
    int mism;
    int cycles;
    int send_idle;
    int recv_idle;
    logic [47:0] clock_ms;

    function automatic t_result mk(logic [2:0] k, logic [31:0] id, logic [15:0] tg, logic l);
        t_result r;
        r.kind = k; r.id = id; r.tgt = tg; r.last = l;
        return r;
    endfunction

    task automatic queue_res(input t_result r);
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic predict_timers(input t_row r);
        t_entry e;
        t_entry kept[$];
        int n;
        bit found;
        n = 0;
        found = 0;
        case (r.op)
            OP_ADD: begin
                if (list_q.size() >= CAP) begin
                    queue_res(mk(K_FULL, 0, 0, 1));
                end else begin
                    e.id = id_ctr; e.target = r.tgt;
                    e.deadline = {1'b0, r.now} + {17'd0, r.delay};
                    e.interval = r.delay; e.once = r.once;
                    list_q.insert(list_q.size(), e);
                    queue_res(mk(K_ADDED, id_ctr, 0, 1));
                    id_ctr++;
                end
            end
            OP_REMOVE: begin
                foreach (list_q[i]) begin
                    if (list_q[i].id == r.rid) found = 1;
                    else kept.insert(kept.size(), list_q[i]);
                end
                list_q = kept;
                queue_res(mk(found ? K_REMOVED : K_NOT_FOUND, r.rid, 0, 1));
            end
            OP_TICK: begin
                foreach (list_q[i]) begin
                    e = list_q[i];
                    if ({1'b0, r.now} >= e.deadline) begin
                        if (n < MAX_RES) begin
                            queue_res(mk(K_FIRED, e.id, e.target, 0));
                            n++;
                        end
                        if (e.once) continue;
                        e.deadline = {1'b0, r.now} + {17'd0, e.interval};
                    end
                    kept.insert(kept.size(), e);
                end
                list_q = kept;
                if (n == 0) queue_res(mk(K_NONE, 0, 0, 1));
                else pending_q[$].last = 1;
            end
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[ordered_timer_list_core] ERROR");
            $finish;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = mk(res_if.kind, res_if.timer_id, res_if.fired_target, res_if.last);
            if (pending_q.size() == 0) begin
                errors++;
                if (mism < 10) $display("unexpected result %p", got);
                mism++;
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (mism < 10) $display("mismatch: expected %p got %p", want, got);
                    mism++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    // entered and left at a falling edge; valid stays high into the next request
    task automatic send(input t_row r);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 0;
            @(negedge i_clk);
        end
        req_if.valid <= 1; req_if.op <= r.op; req_if.now_ms <= r.now;
        req_if.delay_ms <= r.delay; req_if.single_shot <= r.once;
        req_if.target_handle <= r.tgt; req_if.remove_id <= r.rid;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_timers(r);
        if (r.typed) pending_q[$] = r.res;
        @(negedge i_clk);
    endtask

    function automatic t_row row(logic [1:0] op, logic [47:0] now, logic [31:0] dly,
                                 logic once, logic [15:0] tg, logic [31:0] rid);
        t_row r;
        r.op = op; r.now = now; r.delay = dly; r.once = once; r.tgt = tg; r.rid = rid;
        r.typed = 0; r.res = '0;
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, t_result res);
        r.typed = 1; r.res = res;
        return r;
    endfunction

    task automatic random_request();
        t_row r;
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            r = row(OP_ADD, clock_ms, ($urandom_range(9) == 0) ? $urandom : $urandom_range(40),
                    1'($urandom_range(1)), 16'($urandom), 0);
        end else if (sel < 60) begin
            r = row(OP_REMOVE, 0, $urandom, 1'($urandom_range(1)), 16'($urandom),
                    ($urandom_range(3) == 0 || list_q.size() == 0) ? $urandom :
                    list_q[$urandom_range(list_q.size() - 1)].id);
        end else if (sel < 97) begin
            clock_ms = clock_ms + 48'($urandom_range(30));
            r = row(OP_TICK, clock_ms, $urandom, 1'($urandom_range(1)), 16'($urandom),
                    $urandom);
        end else begin
            r = row(2'd3, 48'({$urandom, $urandom}), $urandom, 1'($urandom_range(1)),
                    16'($urandom), $urandom);
        end
        send(r);
    endtask

    initial begin
        t_row dir[$];
        int guard;
        errors = 0; mism = 0; id_ctr = 0;
        send_idle = 15; recv_idle = 51;
        req_if.valid = 0; req_if.op = OP_ADD; req_if.now_ms = 0; req_if.delay_ms = 0;
        req_if.single_shot = 0; req_if.target_handle = 0; req_if.remove_id = 0;
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed table
        dir.insert(dir.size(), typed_row(row(OP_TICK, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0),
                                         mk(K_NONE, 0, 0, 1)));
        dir.insert(dir.size(), typed_row(row(OP_REMOVE, 0, 0, 0, 0, 32'hFFFF_FFFF),
                                         mk(K_NOT_FOUND, 32'hFFFF_FFFF, 0, 1)));
        dir.insert(dir.size(), typed_row(row(OP_ADD, 0, 0, 1, 16'hFFFF, 0),
                                         mk(K_ADDED, 0, 0, 1)));
        dir.insert(dir.size(), row(OP_ADD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 16'h0000, 0));
        dir.insert(dir.size(), row(OP_ADD, 5, 10, 0, 16'hA5A5, 0));
        dir.insert(dir.size(), row(OP_TICK, 0, 0, 0, 0, 0));
        dir.insert(dir.size(), row(OP_TICK, 15, 0, 0, 0, 0));
        dir.insert(dir.size(), row(OP_TICK, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0));
        dir.insert(dir.size(), row(2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 16'hFFFF,
                                   32'hFFFF_FFFF));
        dir.insert(dir.size(), typed_row(row(OP_REMOVE, 0, 0, 0, 0, 2),
                                         mk(K_REMOVED, 2, 0, 1)));
        for (int i = 0; i < 15; i++) begin
            dir.insert(dir.size(), row(OP_ADD, 100, 32'(i), 1'(i & 1),
                                       16'h5A5A ^ 16'(i), 0));
        end
        dir.insert(dir.size(), typed_row(row(OP_ADD, 0, 0, 0, 0, 0), mk(K_FULL, 0, 0, 1)));
        dir.insert(dir.size(), row(OP_TICK, 200, 0, 0, 0, 0));
        dir.insert(dir.size(), row(OP_REMOVE, 0, 0, 0, 0, 1));
        foreach (dir[i]) send(dir[i]);

        // random requests in three idling phases
        clock_ms = 300;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 15 : (phase == 1) ? 51 : 0;
            recv_idle = (phase == 0) ? 51 : (phase == 1) ? 15 : 0;
            for (int k = 0; k < 170; k++) random_request();
        end
        req_if.valid <= 0;

        guard = 0;
        while (pending_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("[ordered_timer_list_core] OK");
        end else begin
            $display("[ordered_timer_list_core] ERROR");
        end
        $finish;
    end
endmodule

// ===== ordered_timer_list_core.f =====
src/otl_pkg.sv
src/otl_if.sv
src/otl_ram.sv
src/ordered_timer_list_core.sv
dv/tb_ordered_timer_list_core.sv
